// ===== hw/rtl/lph_pkg.sv =====
// shared types and constants for the linear probing hash table
package lph_pkg;

  localparam int SLOT_W     = 10;
  localparam int SLOT_COUNT = 2 ** SLOT_W;
  localparam int KEY_W      = 31;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 3;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            entry;
  } mem_wr_t;

endpackage

// ===== hw/rtl/lph_slot_store.sv =====
// slot memory: one write port, one registered read port
module lph_slot_store (
  input  logic                      clk,
  input  lph_pkg::mem_wr_t          wr,
  input  logic [lph_pkg::SLOT_W-1:0] rd_addr,
  output lph_pkg::entry_t           rd_entry
);

  lph_pkg::entry_t mem [lph_pkg::SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule

// ===== hw/rtl/linear_probe_hash_table.sv =====
// top level: linear probing hash table with a probe sequencer
// each request takes p probes, p = 1 to 1024, starting at its home slot
// each probe is a memory read then a compare; a new request is taken only when idle
// the single read port of the slot memory and the shared key compare set the probe rate
// reset: a clearing pass over all 1024 slots empties every slot, no request is taken meanwhile
// output register holds a result until taken; stall on either side is honored
module linear_probe_hash_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [lph_pkg::KEY_W-1:0]     lookup_key,
  input  logic [lph_pkg::DATA_W-1:0]    payload,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lph_pkg::STATUS_W-1:0]  status,
  output logic [lph_pkg::SLOT_W-1:0]    slot,
  output logic [lph_pkg::DATA_W-1:0]    found_payload
);

  // sequencer state
  lph_pkg::state_t state, state_next;

  // probe position and probe count (probe_addr doubles as the clear sweep pointer)
  logic [lph_pkg::SLOT_W-1:0] probe_addr, probe_addr_next;
  logic [lph_pkg::SLOT_W-1:0] probe_cnt, probe_cnt_next;

  // captured request
  logic                       req_kind;
  logic [lph_pkg::KEY_W-1:0]  req_key;
  logic [lph_pkg::DATA_W-1:0] req_data;

  // memory ports
  lph_pkg::mem_wr_t mem_wr;
  lph_pkg::entry_t  rd_entry;

  // probe decision
  logic hit_empty;
  logic hit_key;
  logic last_probe;
  logic probe_done;
  logic out_free;
  logic finish;
  logic accept;

  // result staging
  logic [lph_pkg::STATUS_W-1:0] res_status;
  logic [lph_pkg::SLOT_W-1:0]   res_slot;
  logic [lph_pkg::DATA_W-1:0]   res_data;

  lph_slot_store u_store (
    .clk      (clk),
    .wr       (mem_wr),
    .rd_addr  (probe_addr),
    .rd_entry (rd_entry)
  );

  assign accept = in_valid && !in_stall;

  // shared compare on the word just read
  assign hit_empty  = !rd_entry.valid;
  assign hit_key    = rd_entry.valid && (rd_entry.key == req_key);
  assign last_probe = (probe_cnt == lph_pkg::SLOT_W'(lph_pkg::SLOT_COUNT - 1));
  assign probe_done = hit_empty || hit_key || last_probe;

  // result register can take a new value this cycle
  assign out_free = !out_valid || !out_stall;
  assign finish   = (state == lph_pkg::S_CHECK) && probe_done && out_free;

  // next state and probe pointers
  always_comb begin
    state_next      = state;
    probe_addr_next = probe_addr;
    probe_cnt_next  = probe_cnt;
    case (state)
      lph_pkg::S_CLEAR: begin
        probe_addr_next = probe_addr + 1'b1;
        if (probe_addr == lph_pkg::SLOT_W'(lph_pkg::SLOT_COUNT - 1)) begin
          state_next = lph_pkg::S_IDLE;
        end
      end
      lph_pkg::S_IDLE: begin
        if (accept) begin
          // home slot is key mod slot count
          probe_addr_next = lookup_key[lph_pkg::SLOT_W-1:0];
          probe_cnt_next  = '0;
          state_next      = lph_pkg::S_READ;
        end
      end
      lph_pkg::S_READ: begin
        state_next = lph_pkg::S_CHECK;
      end
      lph_pkg::S_CHECK: begin
        if (!probe_done) begin
          // step forward, wrapping past the last slot
          probe_addr_next = probe_addr + 1'b1;
          probe_cnt_next  = probe_cnt + 1'b1;
          state_next      = lph_pkg::S_READ;
        end else if (out_free) begin
          state_next = lph_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lph_pkg::S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer: handshake, memory write, result word
  always_comb begin
    in_stall          = (state != lph_pkg::S_IDLE);
    mem_wr.en         = 1'b0;
    mem_wr.addr       = probe_addr;
    mem_wr.entry.valid = 1'b0;
    mem_wr.entry.key   = req_key;
    mem_wr.entry.data  = req_data;
    res_status        = lph_pkg::ST_FULL;
    res_slot          = '0;
    res_data          = '0;
    case (state)
      lph_pkg::S_CLEAR: begin
        mem_wr.en = 1'b1;
      end
      lph_pkg::S_CHECK: begin
        if (hit_empty) begin
          if (req_kind == lph_pkg::KIND_LOOKUP) begin
            res_status = lph_pkg::ST_NOT_FOUND;
          end else begin
            res_status         = lph_pkg::ST_INSERTED;
            res_slot           = probe_addr;
            mem_wr.en          = finish;
            mem_wr.entry.valid = 1'b1;
          end
        end else if (hit_key) begin
          res_status = (req_kind == lph_pkg::KIND_LOOKUP) ? lph_pkg::ST_FOUND
                                                          : lph_pkg::ST_DUPLICATE;
          res_slot   = probe_addr;
          res_data   = rd_entry.data;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lph_pkg::S_CLEAR;
      probe_addr <= '0;
      probe_cnt  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      probe_addr <= probe_addr_next;
      probe_cnt  <= probe_cnt_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and result register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_key  <= lookup_key;
      req_data <= payload;
    end
    if (finish) begin
      status        <= res_status;
      slot          <= res_slot;
      found_payload <= res_data;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the linear probing hash table
module tb_top;
  import lph_pkg::*;

  // one request as it goes into the table
  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } request_t;

  // one result as the table reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   data;
  } outcome_t;

  // keys of the fill phase live in a range that random keys never reach,
  // so every fill insert lands on an empty home slot
  localparam logic [KEY_W-1:0] FILL_BASE  = 31'h7000_0000;
  localparam logic [KEY_W-1:0] ABSENT_LO  = 31'h7000_0400;
  localparam logic [KEY_W-1:0] ABSENT_HI  = 31'h7000_07ff;
  localparam logic [KEY_W-1:0] KEY_MAX    = 31'h7fff_ffff;
  localparam logic [DATA_W-1:0] DATA_ONES = 32'hffff_ffff;
  localparam int RANDOM_REQUESTS = 750;
  localparam int IDLE_PCT        = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                kind = KIND_INSERT;
  logic [KEY_W-1:0]    lookup_key = '0;
  logic [DATA_W-1:0]   payload = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [DATA_W-1:0]   found_payload;

  // shadow copy of the slot memory
  logic              tbl_used [SLOT_COUNT];
  logic [KEY_W-1:0]  tbl_key  [SLOT_COUNT];
  logic [DATA_W-1:0] tbl_data [SLOT_COUNT];

  request_t queued_requests[$];
  outcome_t expected_outcomes[$];
  logic [KEY_W-1:0] key_pool[$];

  int accepted_requests = 0;
  int taken_results     = 0;
  int failures          = 0;
  int longest_chain     = 0;
  int seen_status [5]   = '{0, 0, 0, 0, 0};

  always #6 clk = ~clk;

  linear_probe_hash_table u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .lookup_key    (lookup_key),
    .payload       (payload),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .slot          (slot),
    .found_payload (found_payload)
  );

  // walk the shadow table from the home slot, one slot per probe, with wrap;
  // an insert that lands on an empty slot updates the shadow copy
  function automatic outcome_t probe_table(input logic is_lookup_kind,
                                           input logic [KEY_W-1:0] key,
                                           input logic [DATA_W-1:0] data);
    outcome_t res;
    int       pos;
    int       n;
    logic     done;
    res.status = ST_FULL;
    res.slot   = '0;
    res.data   = '0;
    done       = 1'b0;
    pos        = key % SLOT_COUNT;
    for (n = 0; n < SLOT_COUNT && !done; n++) begin
      if (!tbl_used[pos]) begin
        // empty slot ends the walk: miss for a lookup, store for an insert
        if (is_lookup_kind == KIND_LOOKUP) begin
          res.status = ST_NOT_FOUND;
        end else begin
          tbl_used[pos] = 1'b1;
          tbl_key[pos]  = key;
          tbl_data[pos] = data;
          res.status    = ST_INSERTED;
          res.slot      = pos[SLOT_W-1:0];
        end
        done = 1'b1;
      end else if (tbl_key[pos] == key) begin
        res.status = (is_lookup_kind == KIND_LOOKUP) ? ST_FOUND : ST_DUPLICATE;
        res.slot   = pos[SLOT_W-1:0];
        res.data   = tbl_data[pos];
        done       = 1'b1;
      end else begin
        pos = (pos + 1) % SLOT_COUNT;
      end
    end
    // n now counts the probes taken, SLOT_COUNT when the walk gives up on a full table
    if (n > longest_chain) longest_chain = n;
    return res;
  endfunction

  task automatic add_request(input logic k, input logic [KEY_W-1:0] key,
                             input logic [DATA_W-1:0] data);
    request_t r;
    r.kind = k;
    r.key  = key;
    r.data = data;
    queued_requests.push_back(r);
  endtask

  // sampled on the falling edge so the check never races the clocked blocks
  task automatic wait_for_drain();
    while (queued_requests.size() != 0 || expected_outcomes.size() != 0 || in_valid)
      @(negedge clk);
  endtask

  // request driver: the prediction is made at the edge that accepts a request,
  // then the next request is loaded unless this cycle idles
  always @(posedge clk) begin : drive_requests
    request_t nxt;
    logic     steady;
    steady = accepted_requests >= 200 && accepted_requests < 360;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_outcomes.push_back(probe_table(kind, lookup_key, payload));
        accepted_requests++;
      end
      // a stalled request keeps its payload; otherwise the slot is free
      if (!in_valid || !in_stall) begin
        if (queued_requests.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt        = queued_requests.pop_front();
          in_valid   <= 1'b1;
          kind       <= nxt.kind;
          lookup_key <= nxt.key;
          payload    <= nxt.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random back-pressure, field by field compare
  always @(posedge clk) begin : check_results
    outcome_t want;
    logic     steady;
    steady = taken_results >= 400 && taken_results < 560;
    if (!rst) begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      if (out_valid && !out_stall) begin
        taken_results++;
        if (expected_outcomes.size() == 0) begin
          $display("%0t: result with no request pending, got status %0d slot %0d payload %h",
                   $time, status, slot, found_payload);
          failures++;
        end else begin
          want = expected_outcomes.pop_front();
          if (want.status <= ST_FULL) seen_status[want.status]++;
          if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d", $time, want.status, status);
            failures++;
          end
          if (slot !== want.slot) begin
            $display("%0t: slot mismatch, expected %0d, got %0d", $time, want.slot, slot);
            failures++;
          end
          if (found_payload !== want.data) begin
            $display("%0t: payload mismatch, expected %h, got %h",
                     $time, want.data, found_payload);
            failures++;
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic              k;
    int                i;
    int                pick;
    int                home;
    for (i = 0; i < SLOT_COUNT; i++) tbl_used[i] = 1'b0;

    // reset, then the block runs its clearing pass with in_stall high
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table miss, key and payload extremes, duplicate
    add_request(KIND_LOOKUP, '0, DATA_ONES);
    add_request(KIND_INSERT, '0, '0);
    add_request(KIND_INSERT, '0, DATA_ONES);
    add_request(KIND_LOOKUP, '0, '0);
    add_request(KIND_INSERT, KEY_MAX, DATA_ONES);
    // the first home slot is the last one: the probe wraps to the front of the table
    add_request(KIND_INSERT, 31'h0000_03ff, 32'ha5a5_a5a5);
    add_request(KIND_INSERT, 31'h7fff_fc00, 32'h5a5a_5a5a);
    add_request(KIND_LOOKUP, 31'h0000_03ff, '0);
    add_request(KIND_LOOKUP, 31'h7fff_fc00, DATA_ONES);
    // miss after a wrapped chain
    add_request(KIND_LOOKUP, 31'h4000_03ff, '0);
    add_request(KIND_LOOKUP, KEY_MAX, '0);
    add_request(KIND_INSERT, 31'h7fff_fc00, '0);
    add_request(KIND_INSERT, 31'h2aaa_aaaa, 32'h5555_5555);
    add_request(KIND_LOOKUP, 31'h2aaa_aaaa, 32'haaaa_aaaa);
    add_request(KIND_INSERT, 31'h5555_5555, 32'haaaa_aaaa);
    add_request(KIND_LOOKUP, 31'h5555_5555, 32'h5555_5555);
    add_request(KIND_INSERT, 31'h0000_0001, 32'h0000_0001);
    add_request(KIND_LOOKUP, 31'h0000_0001, '0);
    add_request(KIND_LOOKUP, 31'h0000_0002, '0);
    // hold the sender until every directed result is back
    wait_for_drain();

    // random: reused keys for hits and duplicates, keys clustered around the
    // wrap point for long probe chains, and fresh keys over the whole range
    for (i = 0; i < RANDOM_REQUESTS; i++) begin
      k    = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_LOOKUP;
      pick = $urandom_range(0, 99);
      if (pick < 30 && key_pool.size() != 0) begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else if (pick < 55) begin
        home = (SLOT_COUNT - 24 + $urandom_range(0, 60)) % SLOT_COUNT;
        key  = KEY_W'(($urandom & 31'h7fff_fc00) | home);
      end else begin
        key = KEY_W'($urandom);
      end
      // keep clear of the fill range
      if (key[KEY_W-1:KEY_W-3] == 3'b111) key[KEY_W-3] = 1'b0;
      pick = $urandom_range(0, 9);
      data = (pick == 0) ? '0 : (pick == 1) ? DATA_ONES : $urandom;
      key_pool.push_back(key);
      add_request(k, key, data);
    end
    wait_for_drain();

    // fill every slot still empty, each insert on its own home slot
    for (i = 0; i < SLOT_COUNT; i++)
      if (!tbl_used[i]) add_request(KIND_INSERT, FILL_BASE | KEY_W'(i), $urandom);
    // full table: new key and absent lookup give up, hits still work
    add_request(KIND_INSERT, ABSENT_LO, DATA_ONES);
    add_request(KIND_LOOKUP, ABSENT_HI, '0);
    add_request(KIND_LOOKUP, '0, '0);
    add_request(KIND_INSERT, KEY_MAX, '0);
    add_request(KIND_LOOKUP, FILL_BASE | KEY_W'(SLOT_COUNT / 2), '0);
    wait_for_drain();

    // room for a stray result after the longest possible walk
    repeat (2 * SLOT_COUNT + 16) @(posedge clk);
    $display("covered %0d requests: %0d inserted, %0d duplicate, %0d found, %0d missed",
             accepted_requests, seen_status[ST_INSERTED], seen_status[ST_DUPLICATE],
             seen_status[ST_FOUND], seen_status[ST_NOT_FOUND]);
    $display("%0d table-full results, longest probe walk %0d slots",
             seen_status[ST_FULL], longest_chain);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lph_pkg.sv
hw/rtl/lph_slot_store.sv
hw/rtl/linear_probe_hash_table.sv
tb/tb_top.sv
